// ===== sv/hpv_pkg.sv =====
// ----------------------------------------------------------------------------
// Homing PD controller package
// Shared widths, register indexes, reset values and pipeline sideband types.
// ----------------------------------------------------------------------------
package hpv_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int LIM_W         = DATA_W - 1;
    localparam int CFG_IDX_W     = 3;

    localparam int DMAG_W  = DATA_W + 1;
    localparam int DSQ_W   = 2 * DMAG_W;
    localparam int DNORM_W = DMAG_W;
    localparam int VD_W    = LIM_W;
    localparam int VNUM_W  = 2 * DATA_W;

    localparam int FMAG_W  = 2 * DATA_W - FRACTION_BITS;
    localparam int FLO_W   = FMAG_W / 2;
    localparam int FHI_W   = FMAG_W - FLO_W;
    localparam int FSQ_W   = 2 * FMAG_W + 2;
    localparam int FNORM_W = FMAG_W + 1;
    localparam int FNUM_W  = FMAG_W + LIM_W;

    localparam int IN_TDATA_W  = ((6 * DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * DATA_W + 1 + 7) / 8) * 8;

    localparam longint HOMED_EPS = ((longint'(1) << FRACTION_BITS) + 500) / 1000;
    localparam logic [DSQ_W-1:0] HOMED_EPS_SQ = DSQ_W'(HOMED_EPS * HOMED_EPS);
    localparam logic [LIM_W-1:0] SPEED_RESET  = LIM_W'((longint'(15) << FRACTION_BITS) / 100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STIFFNESS,
        REG_DAMPING,
        REG_HOME_X,
        REG_HOME_Y,
        REG_HOME_Z,
        REG_MAX_SPEED,
        REG_MAX_FORCE
    } cfg_reg_t;

    typedef struct packed {
        logic                         homed;
        logic [2:0]                   dneg;
        logic [2:0][DMAG_W-1:0]       dmag;
        logic [2:0][DATA_W-1:0]       vel;
    } dist_side_t;

    typedef struct packed {
        logic                         homed;
        logic [2:0]                   dneg;
        logic [2:0][DATA_W-1:0]       vel;
    } vd_side_t;

    typedef struct packed {
        logic                         homed;
        logic [2:0]                   fneg;
        logic [2:0][FMAG_W-1:0]       fmag;
    } force_side_t;

    typedef struct packed {
        logic                         homed;
        logic                         limited;
        logic [2:0]                   fneg;
        logic [2:0][LIM_W-1:0]        fsmall;
    } clip_side_t;

endpackage

// ===== sv/hpv_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor of the square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module hpv_sqrt_pipe #(
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_radicand,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int REM_W = ROOT_W + 2;

    logic                valid_reg [0:ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg   [0:ROOT_W];
    logic [REM_W-1:0]    rem_reg   [0:ROOT_W];
    logic [REM_W-1:0]    rem_next  [1:ROOT_W];
    logic [ROOT_W-1:0]   root_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]   root_next [1:ROOT_W];
    logic [SIDE_W-1:0]   side_reg  [0:ROOT_W];

    always_comb begin
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        for (int k = 1; k <= ROOT_W; k++) begin
            rem_sh = {rem_reg[k-1], rad_reg[k-1][2*(ROOT_W-k) +: 2]};
            trial  = {2'b00, root_reg[k-1], 2'b01};
            if (rem_sh >= trial) begin
                rem_next[k]  = REM_W'(rem_sh - trial);
                root_next[k] = {root_reg[k-1][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_sh[REM_W-1:0];
                root_next[k] = {root_reg[k-1][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= ROOT_W; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= ROOT_W; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0]  <= in_radicand;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
            for (int k = 1; k <= ROOT_W; k++) begin
                rad_reg[k]  <= rad_reg[k-1];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

// ===== sv/hpv_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Pipelined multi-lane divider
// Restoring division of several numerators by one shared divisor, one
// quotient bit per register stage. The quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module hpv_div_pipe #(
    parameter int LANES  = 3,
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 33,
    parameter int QUO_W  = 31,
    parameter int SIDE_W = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]             in_den,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [LANES-1:0][QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0]            out_side
);

    logic                        valid_reg [0:QUO_W];
    logic [DEN_W-1:0]            den_reg   [0:QUO_W];
    logic [LANES-1:0][DEN_W-1:0] rem_reg   [0:QUO_W];
    logic [LANES-1:0][DEN_W-1:0] rem_next  [1:QUO_W];
    logic [LANES-1:0][QUO_W-1:0] low_reg   [0:QUO_W];
    logic [LANES-1:0][QUO_W-1:0] quo_reg   [0:QUO_W];
    logic [LANES-1:0][QUO_W-1:0] quo_next  [1:QUO_W];
    logic [SIDE_W-1:0]           side_reg  [0:QUO_W];

    always_comb begin
        logic [DEN_W:0] rem_sh;
        for (int k = 1; k <= QUO_W; k++) begin
            for (int l = 0; l < LANES; l++) begin
                rem_sh = {rem_reg[k-1][l], low_reg[k-1][l][QUO_W-k]};
                if (rem_sh >= {1'b0, den_reg[k-1]}) begin
                    rem_next[k][l] = DEN_W'(rem_sh - {1'b0, den_reg[k-1]});
                    quo_next[k][l] = {quo_reg[k-1][l][QUO_W-2:0], 1'b1};
                end else begin
                    rem_next[k][l] = rem_sh[DEN_W-1:0];
                    quo_next[k][l] = {quo_reg[k-1][l][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QUO_W; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= QUO_W; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            quo_reg[0]  <= '0;
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= DEN_W'(in_num[l] >> QUO_W);
                low_reg[0][l] <= in_num[l][QUO_W-1:0];
            end
            for (int k = 1; k <= QUO_W; k++) begin
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
                low_reg[k]  <= low_reg[k-1];
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= quo_next[k];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

// ===== sv/homing_pd_velocity_limited.sv =====
// ----------------------------------------------------------------------------
// Homing PD controller with velocity and force limits
// Turns a position and velocity sample into a saturated homing force.
// ----------------------------------------------------------------------------
// The block accepts one sample per clock cycle while the output is not held,
// and returns one force request per sample, in order, after passing through
// the two bit-serial square root pipelines (offset norm and force norm) and
// the two bit-serial divider pipelines (desired velocity and force scaling).
// The whole pipeline advances together; while a finished result is held on the
// output, the pipeline and the input wait. Configuration registers must only
// be written while no sample is in flight.
module homing_pd_velocity_limited
    import hpv_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DATA_W-1:0]          cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic [IN_TDATA_W-1:0]      s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // force_x, force_y, force_z, homed, zero fill
    output logic [OUT_TDATA_W-1:0]     m_tdata
);

    logic [DATA_W-1:0]      kp_reg;
    logic [DATA_W-1:0]      kv_reg;
    logic [2:0][DATA_W-1:0] home_reg;
    logic [LIM_W-1:0]       max_speed_reg;
    logic [LIM_W-1:0]       max_force_reg;

    logic adv;
    logic m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg        <= '0;
            kv_reg        <= '0;
            home_reg      <= '0;
            max_speed_reg <= SPEED_RESET;
            max_force_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STIFFNESS: kp_reg        <= cfg_data;
                REG_DAMPING:   kv_reg        <= cfg_data;
                REG_HOME_X:    home_reg[0]   <= cfg_data;
                REG_HOME_Y:    home_reg[1]   <= cfg_data;
                REG_HOME_Z:    home_reg[2]   <= cfg_data;
                REG_MAX_SPEED: max_speed_reg <= cfg_data[LIM_W-1:0];
                REG_MAX_FORCE: max_force_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Offset from home and magnitudes.
    logic                   s1_valid_reg;
    logic [2:0]             s1_dneg_reg, s1_dneg_next;
    logic [2:0][DMAG_W-1:0] s1_dmag_reg, s1_dmag_next;
    logic [2:0][DATA_W-1:0] s1_vmag_reg, s1_vmag_next;
    logic [2:0][DATA_W-1:0] s1_vel_reg;

    always_comb begin
        logic [DATA_W-1:0]  pos;
        logic [DATA_W-1:0]  vel;
        logic signed [DATA_W:0] d;
        for (int i = 0; i < 3; i++) begin
            pos = s_tdata[DATA_W*i +: DATA_W];
            vel = s_tdata[DATA_W*(3+i) +: DATA_W];
            d   = $signed({pos[DATA_W-1], pos}) - $signed({home_reg[i][DATA_W-1], home_reg[i]});
            s1_dneg_next[i] = d[DATA_W];
            s1_dmag_next[i] = d[DATA_W] ? DMAG_W'(-d) : DMAG_W'(d);
            s1_vmag_next[i] = vel[DATA_W-1] ? DATA_W'(-vel) : vel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_dneg_reg <= s1_dneg_next;
            s1_dmag_reg <= s1_dmag_next;
            s1_vmag_reg <= s1_vmag_next;
            for (int i = 0; i < 3; i++) begin
                s1_vel_reg[i] <= s_tdata[DATA_W*(3+i) +: DATA_W];
            end
        end
    end

    // Squares.
    logic                     s2_valid_reg;
    logic [2:0][DSQ_W-1:0]    s2_dsq_reg;
    logic [2:0][2*DATA_W-1:0] s2_vsq_reg;
    logic [2:0]               s2_dneg_reg;
    logic [2:0][DMAG_W-1:0]   s2_dmag_reg;
    logic [2:0][DATA_W-1:0]   s2_vel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s2_dsq_reg[i] <= s1_dmag_reg[i] * s1_dmag_reg[i];
                s2_vsq_reg[i] <= s1_vmag_reg[i] * s1_vmag_reg[i];
            end
            s2_dneg_reg <= s1_dneg_reg;
            s2_dmag_reg <= s1_dmag_reg;
            s2_vel_reg  <= s1_vel_reg;
        end
    end

    // Sums, homed flag and offset norm.
    logic [DSQ_W-1:0] dsum;
    logic [DSQ_W-1:0] vsum;
    dist_side_t       dside_in;
    dist_side_t       dside_out;
    logic             dnorm_valid;
    logic [DNORM_W-1:0] dnorm;

    always_comb begin
        dsum = s2_dsq_reg[0] + s2_dsq_reg[1] + s2_dsq_reg[2];
        vsum = DSQ_W'(s2_vsq_reg[0]) + DSQ_W'(s2_vsq_reg[1]) + DSQ_W'(s2_vsq_reg[2]);
        dside_in.homed = (dsum < HOMED_EPS_SQ) && (vsum < HOMED_EPS_SQ);
        dside_in.dneg  = s2_dneg_reg;
        dside_in.dmag  = s2_dmag_reg;
        dside_in.vel   = s2_vel_reg;
    end

    hpv_sqrt_pipe #(
        .ROOT_W (DNORM_W),
        .SIDE_W ($bits(dist_side_t))
    ) u_dist_sqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_valid    (s2_valid_reg),
        .in_radicand (dsum),
        .in_side     (dside_in),
        .out_valid   (dnorm_valid),
        .out_root    (dnorm),
        .out_side    (dside_out)
    );

    // Gain products for the speed limit test and desired velocity.
    logic                           s4_valid_reg;
    logic [DATA_W+DNORM_W-1:0]      s4_kpd_reg;
    logic [LIM_W+DATA_W-1:0]        s4_lkv_reg;
    logic [2:0][VNUM_W-1:0]         s4_ld_reg;
    logic [2:0][DATA_W+DMAG_W-1:0]  s4_kd_reg;
    logic [DNORM_W-1:0]             s4_dnorm_reg;
    vd_side_t                       s4_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= dnorm_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_kpd_reg <= kp_reg * dnorm;
            s4_lkv_reg <= max_speed_reg * kv_reg;
            for (int i = 0; i < 3; i++) begin
                s4_ld_reg[i] <= max_speed_reg * dside_out.dmag[i];
                s4_kd_reg[i] <= kp_reg * dside_out.dmag[i];
            end
            s4_dnorm_reg      <= dnorm;
            s4_side_reg.homed <= dside_out.homed;
            s4_side_reg.dneg  <= dside_out.dneg;
            s4_side_reg.vel   <= dside_out.vel;
        end
    end

    // Desired velocity magnitudes.
    logic                   speed_limited;
    logic [2:0][VNUM_W-1:0] vnum;
    logic [DNORM_W-1:0]     vden;
    logic                   vd_valid;
    logic [2:0][VD_W-1:0]   vd;
    vd_side_t               vside;

    always_comb begin
        speed_limited = (DATA_W+DNORM_W)'(s4_lkv_reg) < s4_kpd_reg;
        for (int i = 0; i < 3; i++) begin
            vnum[i] = speed_limited ? s4_ld_reg[i] : s4_kd_reg[i][VNUM_W-1:0];
        end
        vden = speed_limited ? s4_dnorm_reg : DNORM_W'(kv_reg);
    end

    hpv_div_pipe #(
        .LANES  (3),
        .NUM_W  (VNUM_W),
        .DEN_W  (DNORM_W),
        .QUO_W  (VD_W),
        .SIDE_W ($bits(vd_side_t))
    ) u_vd_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s4_valid_reg),
        .in_num    (vnum),
        .in_den    (vden),
        .in_side   (s4_side_reg),
        .out_valid (vd_valid),
        .out_quo   (vd),
        .out_side  (vside)
    );

    // Velocity error.
    logic                   s6_valid_reg;
    logic [2:0][DATA_W-1:0] s6_emag_reg, s6_emag_next;
    logic [2:0]             s6_fneg_reg, s6_fneg_next;
    logic                   s6_homed_reg;

    always_comb begin
        logic signed [DATA_W:0] vds;
        logic signed [DATA_W:0] e;
        for (int i = 0; i < 3; i++) begin
            vds = vside.dneg[i] ? $signed({2'b00, vd[i]}) : -$signed({2'b00, vd[i]});
            e   = $signed({vside.vel[i][DATA_W-1], vside.vel[i]}) - vds;
            s6_emag_next[i] = e[DATA_W] ? DATA_W'(-e) : e[DATA_W-1:0];
            s6_fneg_next[i] = !e[DATA_W] && (e != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
        end else if (adv) begin
            s6_valid_reg <= vd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_emag_reg  <= s6_emag_next;
            s6_fneg_reg  <= s6_fneg_next;
            s6_homed_reg <= vside.homed;
        end
    end

    // Damping product. A zero damping gain gives a zero force here.
    logic                     s7_valid_reg;
    logic [2:0][FMAG_W-1:0]   s7_fmag_reg;
    logic [2:0]               s7_fneg_reg;
    logic                     s7_homed_reg;
    logic [2:0][2*DATA_W-1:0] damp_prod;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            damp_prod[i] = kv_reg * s6_emag_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_valid_reg <= 1'b0;
        end else if (adv) begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s7_fmag_reg[i] <= damp_prod[i][2*DATA_W-1:FRACTION_BITS];
            end
            s7_fneg_reg  <= s6_fneg_reg;
            s7_homed_reg <= s6_homed_reg;
        end
    end

    // Force squares as partial products.
    logic                          s8_valid_reg;
    logic [2:0][2*FHI_W-1:0]       s8_hh_reg;
    logic [2:0][FHI_W+FLO_W-1:0]   s8_hl_reg;
    logic [2:0][2*FLO_W-1:0]       s8_ll_reg;
    force_side_t                   s8_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s8_valid_reg <= 1'b0;
        end else if (adv) begin
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s8_hh_reg[i] <= s7_fmag_reg[i][FMAG_W-1:FLO_W] * s7_fmag_reg[i][FMAG_W-1:FLO_W];
                s8_hl_reg[i] <= s7_fmag_reg[i][FMAG_W-1:FLO_W] * s7_fmag_reg[i][FLO_W-1:0];
                s8_ll_reg[i] <= s7_fmag_reg[i][FLO_W-1:0] * s7_fmag_reg[i][FLO_W-1:0];
            end
            s8_side_reg.homed <= s7_homed_reg;
            s8_side_reg.fneg  <= s7_fneg_reg;
            s8_side_reg.fmag  <= s7_fmag_reg;
        end
    end

    logic                     s9_valid_reg;
    logic [2:0][2*FMAG_W-1:0] s9_fsq_reg;
    force_side_t              s9_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s9_valid_reg <= 1'b0;
        end else if (adv) begin
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s9_fsq_reg[i] <= ((2*FMAG_W)'(s8_hh_reg[i]) << (2*FLO_W))
                               + ((2*FMAG_W)'(s8_hl_reg[i]) << (FLO_W+1))
                               + (2*FMAG_W)'(s8_ll_reg[i]);
            end
            s9_side_reg <= s8_side_reg;
        end
    end

    // Force norm.
    logic [FSQ_W-1:0]   fsum;
    logic               fnorm_valid;
    logic [FNORM_W-1:0] fnorm;
    force_side_t        fside;

    assign fsum = FSQ_W'(s9_fsq_reg[0]) + FSQ_W'(s9_fsq_reg[1]) + FSQ_W'(s9_fsq_reg[2]);

    hpv_sqrt_pipe #(
        .ROOT_W (FNORM_W),
        .SIDE_W ($bits(force_side_t))
    ) u_force_sqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_valid    (s9_valid_reg),
        .in_radicand (fsum),
        .in_side     (s9_side_reg),
        .out_valid   (fnorm_valid),
        .out_root    (fnorm),
        .out_side    (fside)
    );

    // Force limit products.
    logic                         s11_valid_reg;
    logic [2:0][FHI_W+LIM_W-1:0]  s11_ph_reg;
    logic [2:0][FLO_W+LIM_W-1:0]  s11_pl_reg;
    logic [FNORM_W-1:0]           s11_fnorm_reg;
    clip_side_t                   s11_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s11_valid_reg <= 1'b0;
        end else if (adv) begin
            s11_valid_reg <= fnorm_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s11_ph_reg[i]          <= fside.fmag[i][FMAG_W-1:FLO_W] * max_force_reg;
                s11_pl_reg[i]          <= fside.fmag[i][FLO_W-1:0] * max_force_reg;
                s11_side_reg.fsmall[i] <= fside.fmag[i][LIM_W-1:0];
            end
            s11_fnorm_reg        <= fnorm;
            s11_side_reg.limited <= fnorm > FNORM_W'(max_force_reg);
            s11_side_reg.homed   <= fside.homed;
            s11_side_reg.fneg    <= fside.fneg;
        end
    end

    logic [2:0][FNUM_W-1:0] fnum;
    logic                   clip_valid;
    logic [2:0][LIM_W-1:0]  fclip;
    clip_side_t             cside;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fnum[i] = (FNUM_W'(s11_ph_reg[i]) << FLO_W) + FNUM_W'(s11_pl_reg[i]);
        end
    end

    hpv_div_pipe #(
        .LANES  (3),
        .NUM_W  (FNUM_W),
        .DEN_W  (FNORM_W),
        .QUO_W  (LIM_W),
        .SIDE_W ($bits(clip_side_t))
    ) u_force_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s11_valid_reg),
        .in_num    (fnum),
        .in_den    (s11_fnorm_reg),
        .in_side   (s11_side_reg),
        .out_valid (clip_valid),
        .out_quo   (fclip),
        .out_side  (cside)
    );

    // Output register.
    always_comb begin
        logic [LIM_W-1:0] mag;
        m_tdata_next = '0;
        for (int i = 0; i < 3; i++) begin
            mag = cside.limited ? fclip[i] : cside.fsmall[i];
            m_tdata_next[DATA_W*i +: DATA_W] = cside.fneg[i] ? -{1'b0, mag} : {1'b0, mag};
        end
        m_tdata_next[3*DATA_W] = cside.homed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= clip_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
